/* hdl/ardt_pkg.sv */
package ardt_pkg;

    // Table geometry
    localparam int SLOTS      = 16;
    localparam int SLOT_IDX_W = $clog2(SLOTS);

    // Request codes
    typedef enum logic [1:0] {
        OP_REGISTER   = 2'd0,
        OP_UNREGISTER = 2'd1,
        OP_DISPATCH   = 2'd2
    } op_t;

    // Result codes
    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_MISS    = 3'd1,
        ST_ZERO    = 3'd2,
        ST_OVERLAP = 3'd3,
        ST_FULL    = 3'd4
    } status_t;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE    = 2'd0,
        S_EVAL    = 2'd1,
        S_RESOLVE = 2'd2
    } ctrl_state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;
        logic eval;
        logic commit;
    } ctrl_cmd_t;

endpackage

/* hdl/ardt_req_if.sv */
interface ardt_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [63:0] address;
    logic [63:0] window_size;
    logic [7:0]  handler_tag_in;
    logic        write_access;

    modport source (
        output valid, opcode, address, window_size, handler_tag_in, write_access,
        input  ready
    );

    modport sink (
        input  valid, opcode, address, window_size, handler_tag_in, write_access,
        output ready
    );
endinterface

/* hdl/ardt_rsp_if.sv */
interface ardt_rsp_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [7:0] handler_tag_out;
    logic       read_zeroed;

    modport source (
        output valid, status, handler_tag_out, read_zeroed,
        input  ready
    );

    modport sink (
        input  valid, status, handler_tag_out, read_zeroed,
        output ready
    );
endinterface

/* hdl/ardt_ctrl.sv */
module ardt_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output ardt_pkg::ctrl_cmd_t cmd
);

    ardt_pkg::ctrl_state_t state_reg;
    ardt_pkg::ctrl_state_t state_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;

    // State and result-valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ardt_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Sequence one transaction: capture, compare, resolve and commit
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        case (state_reg)
            ardt_pkg::S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ardt_pkg::S_EVAL;
                end
            end
            ardt_pkg::S_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = ardt_pkg::S_RESOLVE;
            end
            ardt_pkg::S_RESOLVE:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || rsp_ready)
                begin
                    cmd.commit = 1'b1;
                    state_next = ardt_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ardt_pkg::S_IDLE;
            end
        endcase
    end

    // Set on commit, drop when the result is taken
    always_comb
    begin
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign rsp_valid = out_valid_reg;

endmodule

/* hdl/ardt_datapath.sv */
module ardt_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  ardt_pkg::ctrl_cmd_t cmd,
    input  logic [1:0]          opcode,
    input  logic [63:0]         address,
    input  logic [63:0]         window_size,
    input  logic [7:0]          handler_tag_in,
    input  logic                write_access,
    output logic [2:0]          status,
    output logic [7:0]          handler_tag_out,
    output logic                read_zeroed
);

    // Captured request
    logic [1:0]  opcode_reg;
    logic [63:0] address_reg;
    logic [63:0] size_reg;
    logic [7:0]  tag_in_reg;
    logic        write_access_reg;

    // Slot table
    logic [ardt_pkg::SLOTS-1:0] slot_valid_reg;
    logic [63:0]                slot_base_reg   [ardt_pkg::SLOTS];
    logic [63:0]                slot_length_reg [ardt_pkg::SLOTS];
    logic [7:0]                 slot_tag_reg    [ardt_pkg::SLOTS];

    // Per-slot compare results
    logic [ardt_pkg::SLOTS-1:0] clash_next,    clash_reg;
    logic [ardt_pkg::SLOTS-1:0] free_next,     free_reg;
    logic [ardt_pkg::SLOTS-1:0] base_hit_next, base_hit_reg;
    logic [ardt_pkg::SLOTS-1:0] holds_next,    holds_reg;
    logic                       size_zero_next, size_zero_reg;

    // Resolve stage
    logic [ardt_pkg::SLOT_IDX_W-1:0] free_idx;
    logic [ardt_pkg::SLOT_IDX_W-1:0] base_idx;
    logic [ardt_pkg::SLOT_IDX_W-1:0] hold_idx;
    ardt_pkg::status_t               status_next;
    logic [7:0]                      tag_out_next;
    logic                            zeroed_next;
    logic                            do_write;
    logic                            do_clear;

    // Result registers
    ardt_pkg::status_t status_reg;
    logic [7:0]        tag_out_reg;
    logic              zeroed_reg;

    // x lies below y + len, tested without forming the sum
    function automatic logic below_end(logic [63:0] x, logic [63:0] y, logic [63:0] len);
        return (x < y) || ((x - y) < len);
    endfunction

    // Lowest set bit of a slot vector
    function automatic logic [ardt_pkg::SLOT_IDX_W-1:0] first_set(
        logic [ardt_pkg::SLOTS-1:0] v
    );
        logic [ardt_pkg::SLOT_IDX_W-1:0] idx;
        idx = '0;
        for (int i = ardt_pkg::SLOTS - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                idx = ardt_pkg::SLOT_IDX_W'(i);
            end
        end
        return idx;
    endfunction

    // Capture the accepted transaction
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            opcode_reg       <= opcode;
            address_reg      <= address;
            size_reg         <= window_size;
            tag_in_reg       <= handler_tag_in;
            write_access_reg <= write_access;
        end
    end

    // Compare the request against every slot in parallel
    always_comb
    begin
        for (int i = 0; i < ardt_pkg::SLOTS; i++)
        begin
            clash_next[i] = slot_valid_reg[i]
                && below_end(address_reg, slot_base_reg[i], slot_length_reg[i])
                && below_end(slot_base_reg[i], address_reg, size_reg);
            free_next[i]     = !slot_valid_reg[i];
            base_hit_next[i] = slot_valid_reg[i] && (slot_base_reg[i] == address_reg);
            holds_next[i]    = slot_valid_reg[i]
                && (address_reg >= slot_base_reg[i])
                && ((address_reg - slot_base_reg[i]) < slot_length_reg[i]);
        end
        size_zero_next = (size_reg == 64'd0);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.eval)
        begin
            clash_reg     <= clash_next;
            free_reg      <= free_next;
            base_hit_reg  <= base_hit_next;
            holds_reg     <= holds_next;
            size_zero_reg <= size_zero_next;
        end
    end

    assign free_idx = first_set(free_reg);
    assign base_idx = first_set(base_hit_reg);
    assign hold_idx = first_set(holds_reg);

    // Resolve the result and the table update
    always_comb
    begin
        status_next  = ardt_pkg::ST_MISS;
        tag_out_next = 8'd0;
        zeroed_next  = 1'b0;
        do_write     = 1'b0;
        do_clear     = 1'b0;
        case (opcode_reg)
            ardt_pkg::OP_REGISTER:
            begin
                if (size_zero_reg)
                begin
                    status_next = ardt_pkg::ST_ZERO;
                end
                else if (|clash_reg)
                begin
                    status_next = ardt_pkg::ST_OVERLAP;
                end
                else if (!(|free_reg))
                begin
                    status_next = ardt_pkg::ST_FULL;
                end
                else
                begin
                    status_next = ardt_pkg::ST_OK;
                    do_write    = 1'b1;
                end
            end
            ardt_pkg::OP_UNREGISTER:
            begin
                if (|base_hit_reg)
                begin
                    status_next = ardt_pkg::ST_OK;
                    do_clear    = 1'b1;
                end
            end
            ardt_pkg::OP_DISPATCH:
            begin
                if (|holds_reg)
                begin
                    status_next  = ardt_pkg::ST_OK;
                    tag_out_next = slot_tag_reg[hold_idx];
                end
                else
                begin
                    zeroed_next = !write_access_reg;
                end
            end
            default:
            begin
                status_next = ardt_pkg::ST_MISS;
            end
        endcase
    end

    // Slot valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg <= '0;
        end
        else if (cmd.commit)
        begin
            if (do_write)
            begin
                slot_valid_reg[free_idx] <= 1'b1;
            end
            if (do_clear)
            begin
                slot_valid_reg[base_idx] <= 1'b0;
            end
        end
    end

    // Slot contents, written into the lowest free slot
    always_ff @(posedge clk)
    begin
        if (cmd.commit && do_write)
        begin
            slot_base_reg[free_idx]   <= address_reg;
            slot_length_reg[free_idx] <= size_reg;
            slot_tag_reg[free_idx]    <= tag_in_reg;
        end
    end

    // Load the result register
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            status_reg  <= status_next;
            tag_out_reg <= tag_out_next;
            zeroed_reg  <= zeroed_next;
        end
    end

    assign status          = status_reg;
    assign handler_tag_out = tag_out_reg;
    assign read_zeroed     = zeroed_reg;

endmodule

/* hdl/address_range_dispatch_table.sv */
// An accepted request passes the capture, compare and result registers in turn; the
// controller steps capture, the parallel per-slot compare and the resolve/commit
// stage for each request, and takes no new request until it has committed the last.
// A finished result waits in the output register while the next request is taken.
// Reset: rst_n clears the controller, the result valid and all slot valid bits;
// slot contents need no clearing, the block is ready as soon as reset is released.
module address_range_dispatch_table (
    input  logic       clk,
    input  logic       rst_n,
    ardt_req_if.sink   req,
    ardt_rsp_if.source rsp
);

    ardt_pkg::ctrl_cmd_t cmd;

    // Sequencing
    ardt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .cmd       (cmd)
    );

    // Slot table and compare logic
    ardt_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .opcode          (req.opcode),
        .address         (req.address),
        .window_size     (req.window_size),
        .handler_tag_in  (req.handler_tag_in),
        .write_access    (req.write_access),
        .status          (rsp.status),
        .handler_tag_out (rsp.handler_tag_out),
        .read_zeroed     (rsp.read_zeroed)
    );

endmodule

/* hdl/ardt_checker.sv */
module ardt_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       req_valid,
    input logic       req_ready,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input logic [2:0] rsp_status,
    input logic [7:0] rsp_handler_tag_out,
    input logic       rsp_read_zeroed
);

    // Hold a stalled result transaction
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
            && $stable(rsp_handler_tag_out) && $stable(rsp_read_zeroed))
        else $error("result changed while stalled");

    // One request in flight: no back-to-back accept
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted while one is in flight");

    // Zeroed read data only on a miss with no tag
    a_zeroed_miss: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_read_zeroed |->
            rsp_status == ardt_pkg::ST_MISS && rsp_handler_tag_out == 8'd0)
        else $error("read_zeroed without a miss");

    // A tag is reported only with an ok status
    a_tag_on_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status != ardt_pkg::ST_OK |-> rsp_handler_tag_out == 8'd0)
        else $error("handler tag on a failed transaction");

endmodule

bind address_range_dispatch_table ardt_checker u_ardt_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .req_valid           (req.valid),
    .req_ready           (req.ready),
    .rsp_valid           (rsp.valid),
    .rsp_ready           (rsp.ready),
    .rsp_status          (rsp.status),
    .rsp_handler_tag_out (rsp.handler_tag_out),
    .rsp_read_zeroed     (rsp.read_zeroed)
);

/* verif/dispatch_table_checker.sv */
module dispatch_table_checker
    import ardt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    ardt_req_if  req,
    ardt_rsp_if  rsp,
    output int   mismatches,
    output int   pending,
    output int   replies_checked,
    output int   ok_count,
    output int   miss_count,
    output int   refused_count,
    output int   full_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        status_t    status;
        logic [7:0] tag;
        logic       zeroed;
    } reply_t;

    // Shadow copy of the window table
    logic        win_used [SLOTS];
    logic [63:0] win_base [SLOTS];
    logic [63:0] win_len  [SLOTS];
    logic [7:0]  win_tag  [SLOTS];

    reply_t awaiting_replies [$];
    reply_t oldest;
    reply_t predicted;

    initial
    begin
        mismatches      = 0;
        pending         = 0;
        replies_checked = 0;
        ok_count        = 0;
        miss_count      = 0;
        refused_count   = 0;
        full_count      = 0;
    end

    // Two half-open spans [a, a+alen) and [b, b+blen) share a byte; sums at 65 bits
    function automatic logic spans_touch(input logic [63:0] a, input logic [63:0] alen,
                                         input logic [63:0] b, input logic [63:0] blen);
        return ({1'b0, a} < {1'b0, b} + {1'b0, blen}) &&
               ({1'b0, b} < {1'b0, a} + {1'b0, alen});
    endfunction

    // Apply one request to the shadow table and return the reply it must produce
    function automatic reply_t resolve_request(input logic [1:0]  opcode,
                                               input logic [63:0] addr,
                                               input logic [63:0] size,
                                               input logic [7:0]  tag,
                                               input logic        wr);
        reply_t r;
        logic   clash;
        logic   found;
        int     free_idx;
        r.status = ST_MISS;
        r.tag    = 8'h00;
        r.zeroed = 1'b0;
        clash    = 1'b0;
        found    = 1'b0;
        free_idx = -1;
        case (opcode)
            OP_REGISTER:
            begin
                if (size == 64'd0)
                begin
                    r.status = ST_ZERO;
                end
                else
                begin
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        if (win_used[i])
                        begin
                            if (spans_touch(addr, size, win_base[i], win_len[i]))
                                clash = 1'b1;
                        end
                        else if (free_idx < 0)
                        begin
                            free_idx = i;
                        end
                    end
                    if (clash)
                        r.status = ST_OVERLAP;
                    else if (free_idx < 0)
                        r.status = ST_FULL;
                    else
                    begin
                        win_used[free_idx] = 1'b1;
                        win_base[free_idx] = addr;
                        win_len[free_idx]  = size;
                        win_tag[free_idx]  = tag;
                        r.status           = ST_OK;
                    end
                end
            end
            OP_UNREGISTER:
            begin
                // free the lowest slot with a matching base
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (!found && win_used[i] && win_base[i] == addr)
                    begin
                        win_used[i] = 1'b0;
                        found       = 1'b1;
                        r.status    = ST_OK;
                    end
                end
            end
            OP_DISPATCH:
            begin
                // lowest slot whose window holds the address wins
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (!found && win_used[i] && addr >= win_base[i] &&
                        {1'b0, addr} < {1'b0, win_base[i]} + {1'b0, win_len[i]})
                    begin
                        found    = 1'b1;
                        r.status = ST_OK;
                        r.tag    = win_tag[i];
                    end
                end
                if (!found && !wr)
                    r.zeroed = 1'b1;
            end
            default:
            begin
                // spare opcode: miss, no state change
            end
        endcase
        return r;
    endfunction

    // Predict on each request transaction, compare on each result transaction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
                win_used[i] = 1'b0;
            awaiting_replies.delete();
            pending = 0;
        end
        else
        begin
            if (req.valid && req.ready)
            begin
                predicted = resolve_request(req.opcode, req.address, req.window_size,
                                            req.handler_tag_in, req.write_access);
                awaiting_replies.insert(awaiting_replies.size(), predicted);
            end
            if (rsp.valid && rsp.ready)
            begin
                if (awaiting_replies.size() == 0)
                begin
                    $error("result transaction with no request outstanding: status %0d",
                           rsp.status);
                    mismatches++;
                end
                else
                begin
                    oldest = awaiting_replies.pop_front();
                    replies_checked++;
                    if (rsp.status !== oldest.status)
                    begin
                        $error("status: expected %0d, actual %0d", oldest.status,
                               rsp.status);
                        mismatches++;
                    end
                    if (rsp.handler_tag_out !== oldest.tag)
                    begin
                        $error("handler_tag_out: expected 0x%02h, actual 0x%02h",
                               oldest.tag, rsp.handler_tag_out);
                        mismatches++;
                    end
                    if (rsp.read_zeroed !== oldest.zeroed)
                    begin
                        $error("read_zeroed: expected %0b, actual %0b", oldest.zeroed,
                               rsp.read_zeroed);
                        mismatches++;
                    end
                    // tally what the run reached
                    case (oldest.status)
                        ST_OK:      ok_count++;
                        ST_MISS:    miss_count++;
                        ST_FULL:    full_count++;
                        default:    refused_count++;
                    endcase
                end
            end
            pending = awaiting_replies.size();
        end
    end

endmodule

/* verif/tb.sv */
module tb;
    import ardt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] OP_SPARE    = 2'd3;
    localparam int         CYCLE_LIMIT = 400000;
    localparam int         HOLD_CYCLES = 300;
    localparam int         PHASE_ITEMS = 584;
    localparam int         DRAIN_WAIT  = 16;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [63:0] address;
        logic [63:0] window_size;
        logic [7:0]  tag;
        logic        write_access;
    } request_t;

    logic clk;
    logic rst_n;

    ardt_req_if req_bus ();
    ardt_rsp_if rsp_bus ();

    int mismatches;
    int pending;
    int replies_checked;
    int ok_count;
    int miss_count;
    int refused_count;
    int full_count;

    int src_idle_pct;
    int sink_idle_pct;
    int hold_token;
    int hold_seen;
    int hold_left;
    int cycle_count;
    int n_register;
    int n_unregister;
    int n_dispatch;
    int n_spare;

    logic [63:0] prefix_pool [4];
    logic [63:0] scramble;

    address_range_dispatch_table dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    dispatch_table_checker chk (
        .clk             (clk),
        .rst_n           (rst_n),
        .req             (req_bus),
        .rsp             (rsp_bus),
        .mismatches      (mismatches),
        .pending         (pending),
        .replies_checked (replies_checked),
        .ok_count        (ok_count),
        .miss_count      (miss_count),
        .refused_count   (refused_count),
        .full_count      (full_count)
    );

    // Free-running clock, 20 ns period
    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    // Abort a hung run
    initial
    begin
        cycle_count = 0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("address_range_dispatch_table verification failed");
            $finish;
        end
    end

    // Result side: random back-pressure, plus one long hold when requested
    always @(negedge clk)
    begin
        if (hold_token != hold_seen)
        begin
            hold_seen = hold_token;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            rsp_bus.ready <= 1'b0;
            hold_left--;
        end
        else
        begin
            rsp_bus.ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // Offer one request transaction and hold it until accepted
    task automatic offer(input request_t r);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            req_bus.valid <= 1'b0;
            @(negedge clk);
        end
        req_bus.valid          <= 1'b1;
        req_bus.opcode         <= r.opcode;
        req_bus.address        <= r.address;
        req_bus.window_size    <= r.window_size;
        req_bus.handler_tag_in <= r.tag;
        req_bus.write_access   <= r.write_access;
        @(posedge clk);
        while (!req_bus.ready)
            @(posedge clk);
        case (r.opcode)
            OP_REGISTER:   n_register++;
            OP_UNREGISTER: n_unregister++;
            OP_DISPATCH:   n_dispatch++;
            default:       n_spare++;
        endcase
    endtask

    // Mostly grid-aligned windows so registers, unregisters and dispatches collide
    function automatic request_t pick_request();
        request_t    r;
        int          roll;
        int          pick;
        logic [63:0] base;
        roll           = $urandom_range(99);
        pick           = $urandom_range(99);
        base           = prefix_pool[2'($urandom_range(3))] + (64'($urandom_range(7)) << 12);
        r.address      = base;
        r.window_size  = {$urandom, $urandom};
        r.tag          = 8'($urandom);
        r.write_access = 1'($urandom);
        if (roll < 38)
        begin
            r.opcode = OP_REGISTER;
            if (pick < 70)
                r.window_size = 64'($urandom_range(1, 4096));
            else if (pick < 88)
                r.window_size = 64'($urandom_range(4097, 12288));
            else if (pick < 94)
                r.window_size = 64'd0;
            if ($urandom_range(4) == 0)
                r.address = base + 64'($urandom_range(1, 4095));
        end
        else if (roll < 60)
        begin
            r.opcode = OP_UNREGISTER;
            if (pick >= 95)
                r.address = {$urandom, $urandom};
            else if (pick >= 85)
                r.address = base + 64'($urandom_range(1, 4095));
        end
        else if (roll < 95)
        begin
            r.opcode = OP_DISPATCH;
            if (pick < 45)
                r.address = base + 64'($urandom_range(0, 4095));
            else if (pick < 65)
                r.address = base;
            else if (pick < 80)
                r.address = base + 64'h0FFF;
            else if (pick < 95)
                r.address = base + 64'($urandom_range(4096, 12287));
            else
                r.address = {$urandom, $urandom};
        end
        else
        begin
            r.opcode  = OP_SPARE;
            r.address = {$urandom, $urandom};
        end
        return r;
    endfunction

    task automatic run_random(input int count);
        for (int i = 0; i < count; i++)
            offer(pick_request());
    endtask

    // Stimulus
    initial
    begin
        rst_n                  = 1'b0;
        req_bus.valid          = 1'b0;
        req_bus.opcode         = OP_REGISTER;
        req_bus.address        = 64'd0;
        req_bus.window_size    = 64'd0;
        req_bus.handler_tag_in = 8'd0;
        req_bus.write_access   = 1'b0;
        rsp_bus.ready          = 1'b0;
        src_idle_pct           = 25;
        sink_idle_pct          = 87;
        hold_token             = 0;
        hold_seen              = 0;
        hold_left              = 0;
        n_register             = 0;
        n_unregister           = 0;
        n_dispatch             = 0;
        n_spare                = 0;

        // address prefixes: bottom, top of the space, a random one and its complement
        scramble       = {$urandom, $urandom} & ~64'h7FFF;
        prefix_pool[0] = 64'd0;
        prefix_pool[1] = 64'hFFFF_FFFF_FFFF_8000;
        prefix_pool[2] = scramble;
        prefix_pool[3] = ~scramble & ~64'h7FFF;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty table, refusals, window ending at the top of the space
        offer('{OP_DISPATCH,   64'd0,                 64'd0, 8'h00, 1'b0});
        offer('{OP_DISPATCH,   64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                8'hFF, 1'b1});
        offer('{OP_REGISTER,   64'h40,                64'd0, 8'h11, 1'b0});
        offer('{OP_REGISTER,   64'd0,                 64'd1, 8'hFF, 1'b0});
        offer('{OP_REGISTER,   64'hFFFF_FFFF_FFFF_F000, 64'h1000, 8'hA5, 1'b0});
        offer('{OP_REGISTER,   64'd1,                 64'hFFFF_FFFF_FFFF_FFFF,
                8'h22, 1'b0});
        offer('{OP_REGISTER,   64'hFFFF_FFFF_FFFF_FFFF, 64'd1, 8'h33, 1'b1});
        offer('{OP_DISPATCH,   64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 8'h00, 1'b0});
        offer('{OP_DISPATCH,   64'd1,                 64'd0, 8'h00, 1'b0});
        offer('{OP_UNREGISTER, 64'd5,                 64'd7, 8'h44, 1'b1});
        offer('{OP_SPARE,      64'd0,                 64'd1, 8'h55, 1'b1});
        // fill every remaining slot, then one more register finds the table full
        for (int k = 1; k <= 7; k++)
            offer('{OP_REGISTER, 64'(k) << 12, 64'h1000, 8'(k), 1'b0});
        for (int k = 0; k <= 6; k++)
            offer('{OP_REGISTER, 64'hFFFF_FFFF_FFFF_8000 + (64'(k) << 12), 64'h1000,
                    8'(8'h80 + k), 1'b0});
        offer('{OP_REGISTER,   64'h10_0000,           64'd1, 8'h66, 1'b0});
        offer('{OP_UNREGISTER, 64'd0,                 64'd0, 8'h00, 1'b0});

        // Random, receiver mostly stalled
        run_random(PHASE_ITEMS);

        // Random, sender mostly idle
        src_idle_pct  = 87;
        sink_idle_pct = 25;
        run_random(PHASE_ITEMS);

        // Random at full rate, starting with a long output hold to back up the block
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        hold_token    = hold_token + 1;
        run_random(PHASE_ITEMS);

        @(negedge clk);
        req_bus.valid <= 1'b0;

        // Drain outstanding results, then watch for strays
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);

        $display("Sent %0d requests: %0d register, %0d unregister, %0d dispatch, %0d spare op",
                 n_register + n_unregister + n_dispatch + n_spare, n_register,
                 n_unregister, n_dispatch, n_spare);
        $display("Checked %0d results: %0d ok, %0d miss, %0d zero/overlap, %0d full",
                 replies_checked, ok_count, miss_count, refused_count, full_count);
        if (mismatches == 0)
        begin
            $display("address_range_dispatch_table verification clean");
        end
        else
        begin
            $display("address_range_dispatch_table verification failed");
        end
        $finish;
    end

endmodule
